// ===== design/pstb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_pkg
// Shared types and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
package pstb_pkg;

    localparam int SLOTS   = 16;                                // 1 .. 16
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot address
    localparam int CNT_W   = $clog2(SLOTS + 1);                 // 0 .. SLOTS
    localparam int FIRED_W = 16;
    localparam int TIMER_W = 32;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_DELETE = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } state_t;

    // one result item, fired_mask in the lowest bits
    typedef struct packed {
        logic [4:0]         live_count;
        logic               slot_running;
        status_t            status;
        logic [3:0]         created_slot;
        logic [FIRED_W-1:0] fired_mask;
    } res_t;

endpackage

// ===== design/periodic_software_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_software_timer_bank_unit
// Bank of periodic timer slots driven by create/delete/start/stop/query/tick.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+-----------
//  s_      | in  | slot_index[3:0], period_ticks[35:4]      | func[2:0]
//  m_      | out | fired_mask[15:0], created_slot[19:16],   | -
//          |     | status[21:20], slot_running[22],         |
//          |     | live_count[27:23]                        |
//
//  Create, delete, start, stop, query and unknown ops: accept, then
//  execute and write the result register.
//  Tick: a walk over the period and count RAMs, one slot read per cycle
//  with write-back in the cycle after the read.
//  Reset: synchronous, active low; clears slot flags and live count. The
//  RAMs hold no reset value; every entry is written by create before use.
//  A new item is taken while the previous result waits on m_tready; that
//  item's execute step holds until the output register frees.
//
module periodic_software_timer_bank_unit import pstb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot_index, period_ticks
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // fired_mask, created_slot, status,
                                   // slot_running, live_count
);

    logic               out_free;
    logic               res_valid;
    res_t               res;

    logic               ram_rd_en;
    logic [SLOT_W-1:0]  ram_rd_addr;
    logic [SLOT_W-1:0]  ram_wr_addr;
    logic               per_we;
    logic [TIMER_W-1:0] per_wdata;
    logic [TIMER_W-1:0] per_rdata;
    logic               cnt_we;
    logic [TIMER_W-1:0] cnt_wdata;
    logic [TIMER_W-1:0] cnt_rdata;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    res_t               m_res_reg, m_res_next;

    assign out_free = !m_tvalid_reg || m_tready;

    pstb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_slot     (s_tdata[3:0]),
        .in_period   (s_tdata[35:4]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_wr_addr (ram_wr_addr),
        .per_we      (per_we),
        .per_wdata   (per_wdata),
        .per_rdata   (per_rdata),
        .cnt_we      (cnt_we),
        .cnt_wdata   (cnt_wdata),
        .cnt_rdata   (cnt_rdata)
    );

    // per-slot period
    pstb_ram #(
        .DEPTH (SLOTS),
        .WIDTH (TIMER_W)
    ) u_period_ram (
        .aclk    (aclk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (per_rdata),
        .wr_en   (per_we),
        .wr_addr (ram_wr_addr),
        .wr_data (per_wdata)
    );

    // per-slot running count
    pstb_ram #(
        .DEPTH (SLOTS),
        .WIDTH (TIMER_W)
    ) u_count_ram (
        .aclk    (aclk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (cnt_rdata),
        .wr_en   (cnt_we),
        .wr_addr (ram_wr_addr),
        .wr_data (cnt_wdata)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_res_reg};

`ifndef NO_ASSERTIONS
    // a result is only produced when the output register can take it
    a_res_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result produced while output register is full");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in flight");

    // a tick walks the RAMs, so no result in the cycle after its accept
    a_tick_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_TICK)) |=> !res_valid)
        else $error("tick result without walking the slots");

    // a full bank means every slot is counted live
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == ST_FULL)) |-> (res.live_count == 5'(SLOTS)))
        else $error("bank full reported with live count below slot count");
`endif

endmodule

// ===== design/pstb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pstb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/pstb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_ctrl
// Operation sequencer: slot flags, live count and the tick walk over the RAMs.
// ----------------------------------------------------------------------------
module pstb_ctrl import pstb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // item in
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_func,
    input  logic [3:0]         in_slot,
    input  logic [TIMER_W-1:0] in_period,
    // result out
    input  logic               out_free,
    output logic               res_valid,
    output res_t               res,
    // RAM side
    output logic               ram_rd_en,
    output logic [SLOT_W-1:0]  ram_rd_addr,
    output logic [SLOT_W-1:0]  ram_wr_addr,
    output logic               per_we,
    output logic [TIMER_W-1:0] per_wdata,
    input  logic [TIMER_W-1:0] per_rdata,
    output logic               cnt_we,
    output logic [TIMER_W-1:0] cnt_wdata,
    input  logic [TIMER_W-1:0] cnt_rdata
);

    state_t             state_reg, state_next;
    logic [2:0]         func_reg, func_next;
    logic [3:0]         slot_reg, slot_next;
    logic [TIMER_W-1:0] period_reg, period_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [SLOTS-1:0]   en_reg, en_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               p_valid_reg, p_valid_next;
    logic [SLOT_W-1:0]  p_idx_reg, p_idx_next;
    logic [FIRED_W-1:0] fired_reg, fired_next;

    logic [SLOT_W-1:0]  slot_w;
    logic               slot_ok;
    logic [SLOT_W-1:0]  free_idx;
    logic               all_used;
    logic               walk_end;
    logic [TIMER_W-1:0] cnt_inc;
    logic               hit;

    assign slot_w   = SLOT_W'(slot_reg);
    assign slot_ok  = (int'(slot_reg) < SLOTS) && used_reg[slot_w];
    assign all_used = &used_reg;
    assign walk_end = (rd_cnt_reg == CNT_W'(SLOTS));
    assign cnt_inc  = cnt_rdata + TIMER_W'(1);
    assign hit      = (cnt_inc == per_rdata);

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = (in_func == OP_TICK) ? S_WALK : S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_ready     = (state_reg == S_IDLE);
        func_next    = func_reg;
        slot_next    = slot_reg;
        period_next  = period_reg;
        used_next    = used_reg;
        en_next      = en_reg;
        total_next   = total_reg;
        rd_cnt_next  = rd_cnt_reg;
        p_valid_next = 1'b0;
        p_idx_next   = p_idx_reg;
        fired_next   = fired_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = ST_OK;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = rd_cnt_reg[SLOT_W-1:0];
        ram_wr_addr  = slot_w;
        per_we       = 1'b0;
        per_wdata    = period_reg;
        cnt_we       = 1'b0;
        cnt_wdata    = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    func_next   = in_func;
                    slot_next   = in_slot;
                    period_next = in_period;
                    rd_cnt_next = '0;
                    fired_next  = '0;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    case (func_reg)
                        OP_CREATE: begin
                            if (!all_used) begin
                                used_next[free_idx] = 1'b1;
                                en_next[free_idx]   = 1'b0;
                                total_next          = total_reg + CNT_W'(1);
                                ram_wr_addr         = free_idx;
                                per_we              = 1'b1;
                                cnt_we              = 1'b1;
                                res.created_slot    = 4'(free_idx);
                            end else begin
                                res.status = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            if (slot_ok) begin
                                used_next[slot_w] = 1'b0;
                                en_next[slot_w]   = 1'b0;
                                total_next        = total_reg - CNT_W'(1);
                            end else begin
                                res.status = ST_BAD;
                            end
                        end
                        OP_START: begin
                            if (slot_ok) begin
                                en_next[slot_w]  = 1'b1;
                                res.slot_running = 1'b1;
                            end else begin
                                res.status = ST_BAD;
                            end
                        end
                        OP_STOP: begin
                            if (slot_ok) begin
                                en_next[slot_w] = 1'b0;
                                cnt_we          = 1'b1;
                            end else begin
                                res.status = ST_BAD;
                            end
                        end
                        OP_QUERY: begin
                            if (slot_ok) begin
                                res.slot_running = en_reg[slot_w];
                            end else begin
                                res.status = ST_BAD;
                            end
                        end
                        default: res.status = ST_BAD;
                    endcase
                    res.live_count = 5'(total_next);
                end
            end
            S_WALK: begin
                // read slot n while slot n-1 is written back
                if (!walk_end) begin
                    ram_rd_en    = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    p_valid_next = 1'b1;
                    p_idx_next   = rd_cnt_reg[SLOT_W-1:0];
                end
                if (p_valid_reg && used_reg[p_idx_reg] && en_reg[p_idx_reg]) begin
                    ram_wr_addr = p_idx_reg;
                    cnt_we      = 1'b1;
                    cnt_wdata   = hit ? '0 : cnt_inc;
                    if (hit) begin
                        fired_next = fired_reg | (FIRED_W'(1) << p_idx_reg);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    res_valid      = 1'b1;
                    res.fired_mask = fired_reg;
                    res.live_count = 5'(total_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            en_reg      <= '0;
            total_reg   <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            en_reg      <= en_next;
            total_reg   <= total_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        slot_reg   <= slot_next;
        period_reg <= period_next;
        rd_cnt_reg <= rd_cnt_next;
        p_idx_reg  <= p_idx_next;
        fired_reg  <= fired_next;
    end

endmodule
